### src/fgt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register map and helpers of the two-input fuzzy gain tuner.
package fgt_pkg;

   localparam int ERR_SETS_DEFAULT  = 4;
   localparam int CHG_SETS_DEFAULT  = 5;
   localparam int FRAC_BITS_DEFAULT = 8;

   localparam int DATA_W       = 16;
   localparam int STEP_W       = 15;
   localparam int DIFF_W       = 20;
   localparam int CODE_W       = 3;
   localparam int OUT_SETS     = 5;
   localparam int RULE_ENTRIES = 20;
   localparam int TABLE_W      = 60;
   localparam int RIDX_W       = 6;
   localparam int CENTER_W     = 19;
   localparam int QUO_BITS     = 19;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;

   localparam logic [CSR_IDX_W-1:0] CSR_ERR_START  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHG_START  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHG_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_START  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_STEP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_TABLE = 3'd6;

   localparam logic signed [DATA_W-1:0] ERR_START_RESET = 16'sd26;
   localparam logic [STEP_W-1:0]        ERR_STEP_RESET  = 15'd179;
   localparam logic signed [DATA_W-1:0] CHG_START_RESET = -16'sd23040;
   localparam logic [STEP_W-1:0]        CHG_STEP_RESET  = 15'd11520;
   localparam logic signed [DATA_W-1:0] OUT_START_RESET = -16'sd23040;
   localparam logic [STEP_W-1:0]        OUT_STEP_RESET  = 15'd11520;
   localparam logic [TABLE_W-1:0]       RULE_TABLE_RESET = 60'd329406212897055322;

   localparam logic [CODE_W-1:0] CODE_LEFT  = 3'd0;
   localparam logic [CODE_W-1:0] CODE_RIGHT = CODE_W'(OUT_SETS - 1);

   function automatic logic [STEP_W-1:0] step_fix(input logic [STEP_W-1:0] s);
      return (s == '0) ? STEP_W'(1) : s;
   endfunction

endpackage

### src/fuzzy_gain_tuner_two_input.sv
`timescale 1ns / 1ps
// Top level of the two-input fuzzy gain tuner: grading, rule firing and centroid pipeline.
//
// One result per accepted item, and a new item may be started in every cycle. The
// pipeline includes the grade divider (one stage per fraction bit) and the centroid
// divider (one stage per quotient bit, 19 stages). busy stays low; the result strobe
// rsp_valid cannot be held off by the receiver. Write configuration only while no
// item is in flight.
module fuzzy_gain_tuner_two_input
   import fgt_pkg::*;
#(
   parameter int ERR_SETS  = ERR_SETS_DEFAULT,
   parameter int CHG_SETS  = CHG_SETS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_error_value,
   input  logic signed [DATA_W-1:0] req_change_value,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_gain_change,
   output logic                     rsp_no_rule_fired,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data
);

   localparam int F       = FRAC_BITS;
   localparam int IE_W    = $clog2(ERR_SETS);
   localparam int IC_W    = $clog2(CHG_SETS);
   localparam int G_W     = F + 1;
   localparam int K_W     = 2 * F + 1;
   localparam int W_W     = 2 * F + 2;
   localparam int WQ_W    = W_W + 1 + CENTER_W;
   localparam int U2_W    = 2 * F + 1;
   localparam int U3_W    = 3 * F + 1;
   localparam int OFF_W   = U3_W + STEP_W;
   localparam int NT_W    = WQ_W + F + 3;
   localparam int DT_W    = W_W + F + 2;
   localparam int NS_W    = NT_W + 2;
   localparam int DS_W    = DT_W + 2;
   localparam int N2_W    = NS_W + 2;
   localparam int D2_W    = DS_W + 1;
   localparam int C_W     = N2_W + QUO_BITS + 1;
   localparam int R_W     = QUO_BITS + 2;
   localparam int LATENCY = F + QUO_BITS + 11;

   typedef struct packed {
      logic              fnd;
      logic              full;
      logic [STEP_W-1:0] rem;
      logic [F-1:0]      quo;
   } lane_type;

   typedef struct packed {
      logic [N2_W-1:0]     rem;
      logic [QUO_BITS-1:0] quo;
      logic [D2_W-1:0]     den;
      logic                neg;
      logic                zero;
   } quot_type;

   // configuration registers
   logic signed [DATA_W-1:0] err_start_ff, chg_start_ff, out_start_ff;
   logic [STEP_W-1:0]        err_step_ff, chg_step_ff, out_step_ff;
   logic [TABLE_W-1:0]       rule_table_ff;
   logic [STEP_W-1:0]        es, cs, os;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_start_ff  <= ERR_START_RESET;
         err_step_ff   <= ERR_STEP_RESET;
         chg_start_ff  <= CHG_START_RESET;
         chg_step_ff   <= CHG_STEP_RESET;
         out_start_ff  <= OUT_START_RESET;
         out_step_ff   <= OUT_STEP_RESET;
         rule_table_ff <= RULE_TABLE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ERR_START:  err_start_ff  <= csr_write_data[DATA_W-1:0];
            CSR_ERR_STEP:   err_step_ff   <= csr_write_data[STEP_W-1:0];
            CSR_CHG_START:  chg_start_ff  <= csr_write_data[DATA_W-1:0];
            CSR_CHG_STEP:   chg_step_ff   <= csr_write_data[STEP_W-1:0];
            CSR_OUT_START:  out_start_ff  <= csr_write_data[DATA_W-1:0];
            CSR_OUT_STEP:   out_step_ff   <= csr_write_data[STEP_W-1:0];
            CSR_RULE_TABLE: rule_table_ff <= csr_write_data[TABLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign es   = step_fix(err_step_ff);
   assign cs   = step_fix(chg_step_ff);
   assign os   = step_fix(out_step_ff);
   assign busy = 1'b0;

   // stage 1: distance to every set peak
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] s1_de_ff [ERR_SETS];
   logic signed [DIFF_W-1:0] s1_dc_ff [CHG_SETS];
   logic signed [DIFF_W-1:0] s1_de_in [ERR_SETS];
   logic signed [DIFF_W-1:0] s1_dc_in [CHG_SETS];

   always_comb begin
      for (int k = 0; k < ERR_SETS; k++) begin
         s1_de_in[k] = DIFF_W'(req_error_value) - DIFF_W'(err_start_ff)
                       - DIFF_W'(k * int'(es));
      end
      for (int k = 0; k < CHG_SETS; k++) begin
         s1_dc_in[k] = DIFF_W'(req_change_value) - DIFF_W'(chg_start_ff)
                       - DIFF_W'(k * int'(cs));
      end
   end

   always_ff @(posedge clock) begin
      s1_valid_ff <= reset ? 1'b0 : (start && !busy);
      s1_de_ff    <= s1_de_in;
      s1_dc_ff    <= s1_dc_in;
   end

   // stage 2: pick the first two active sets of each input
   logic                  s2_valid_ff;
   lane_type              s2_lane_ff [4];
   lane_type              s2_lane_in [4];
   logic [2*IE_W-1:0]     s2_ie_ff, s2_ie_in;
   logic [2*IC_W-1:0]     s2_ic_ff, s2_ic_in;

   always_comb begin
      logic [1:0]        cnt;
      logic [DIFF_W-1:0] ad;
      logic              fl;
      logic              nz;
      for (int l = 0; l < 4; l++) begin
         s2_lane_in[l] = '0;
      end
      s2_ie_in = '0;
      s2_ic_in = '0;
      cnt = '0;
      for (int k = 0; k < ERR_SETS; k++) begin
         ad = s1_de_ff[k][DIFF_W-1] ? DIFF_W'(-s1_de_ff[k]) : DIFF_W'(s1_de_ff[k]);
         fl = (s1_de_ff[k] == 0) || (k == 0 && s1_de_ff[k] < 0)
              || (k == ERR_SETS - 1 && s1_de_ff[k] > 0);
         nz = fl || (ad < DIFF_W'(es));
         if (nz && cnt < 2'd2) begin
            s2_lane_in[cnt[0]].fnd  = 1'b1;
            s2_lane_in[cnt[0]].full = fl;
            s2_lane_in[cnt[0]].rem  = es - ad[STEP_W-1:0];
            s2_ie_in[cnt[0]*IE_W +: IE_W] = IE_W'(k);
            cnt = cnt + 2'd1;
         end
      end
      cnt = '0;
      for (int k = 0; k < CHG_SETS; k++) begin
         ad = s1_dc_ff[k][DIFF_W-1] ? DIFF_W'(-s1_dc_ff[k]) : DIFF_W'(s1_dc_ff[k]);
         fl = (s1_dc_ff[k] == 0) || (k == 0 && s1_dc_ff[k] < 0)
              || (k == CHG_SETS - 1 && s1_dc_ff[k] > 0);
         nz = fl || (ad < DIFF_W'(cs));
         if (nz && cnt < 2'd2) begin
            s2_lane_in[2 + int'(cnt[0])].fnd  = 1'b1;
            s2_lane_in[2 + int'(cnt[0])].full = fl;
            s2_lane_in[2 + int'(cnt[0])].rem  = cs - ad[STEP_W-1:0];
            s2_ic_in[cnt[0]*IC_W +: IC_W] = IC_W'(k);
            cnt = cnt + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_valid_ff <= reset ? 1'b0 : s1_valid_ff;
      s2_lane_ff  <= s2_lane_in;
      s2_ie_ff    <= s2_ie_in;
      s2_ic_ff    <= s2_ic_in;
   end

   // grade divider: one quotient bit per stage on four lanes
   logic              gd_valid_ff [F];
   lane_type          gd_ff [F][4];
   lane_type          gd_in [F][4];
   logic [2*IE_W-1:0] gd_ie_ff [F];
   logic [2*IC_W-1:0] gd_ic_ff [F];

   always_comb begin
      lane_type          src;
      logic [STEP_W:0]   r2;
      logic [STEP_W-1:0] dv;
      for (int j = 0; j < F; j++) begin
         for (int l = 0; l < 4; l++) begin
            src = (j == 0) ? s2_lane_ff[l] : gd_ff[(j == 0) ? 0 : j - 1][l];
            dv  = (l < 2) ? es : cs;
            r2  = {src.rem, 1'b0};
            gd_in[j][l] = src;
            if (r2 >= {1'b0, dv}) begin
               gd_in[j][l].rem = STEP_W'(r2 - {1'b0, dv});
               gd_in[j][l].quo = {src.quo[F-2:0], 1'b1};
            end else begin
               gd_in[j][l].rem = r2[STEP_W-1:0];
               gd_in[j][l].quo = {src.quo[F-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      gd_ff <= gd_in;
      for (int j = 0; j < F; j++) begin
         if (j == 0) begin
            gd_valid_ff[j] <= reset ? 1'b0 : s2_valid_ff;
            gd_ie_ff[j]    <= s2_ie_ff;
            gd_ic_ff[j]    <= s2_ic_ff;
         end else begin
            gd_valid_ff[j] <= reset ? 1'b0 : gd_valid_ff[j-1];
            gd_ie_ff[j]    <= gd_ie_ff[j-1];
            gd_ic_ff[j]    <= gd_ic_ff[j-1];
         end
      end
   end

   // rule stage 1: strength and output set of each rule
   logic [G_W-1:0]    grade [4];
   logic              r1_valid_ff;
   logic [G_W-1:0]    r1_a_ff [4], r1_a_in [4];
   logic [CODE_W-1:0] r1_code_ff [4], r1_code_in [4];

   always_comb begin
      logic [G_W-1:0]     ga, gb;
      logic [RIDX_W-1:0]  ridx;
      logic [CODE_W-1:0]  code;
      for (int l = 0; l < 4; l++) begin
         grade[l] = gd_ff[F-1][l].full ? (G_W'(1) << F)
                  : gd_ff[F-1][l].fnd ? {1'b0, gd_ff[F-1][l].quo} : '0;
      end
      for (int a = 0; a < 2; a++) begin
         for (int b = 0; b < 2; b++) begin
            ga   = grade[a];
            gb   = grade[2 + b];
            ridx = RIDX_W'(gd_ie_ff[F-1][a*IE_W +: IE_W]) * RIDX_W'(CHG_SETS)
                   + RIDX_W'(gd_ic_ff[F-1][b*IC_W +: IC_W]);
            code = (ridx < RIDX_W'(RULE_ENTRIES))
                   ? CODE_W'(rule_table_ff >> (8'(ridx) * 8'd3)) : CODE_LEFT;
            if (code > CODE_RIGHT) begin
               code = CODE_RIGHT;
            end
            r1_a_in[a*2 + b]    = (ga < gb) ? ga : gb;
            r1_code_in[a*2 + b] = code;
         end
      end
   end

   always_ff @(posedge clock) begin
      r1_valid_ff <= reset ? 1'b0 : gd_valid_ff[F-1];
      r1_a_ff     <= r1_a_in;
      r1_code_ff  <= r1_code_in;
   end

   // rule stage 2: clipped-area factors and set centers
   logic                       r2_valid_ff;
   logic [K_W-1:0]             r2_k_ff [4], r2_k_in [4];
   logic [G_W-1:0]             r2_u_ff [4], r2_u_in [4];
   logic [U2_W-1:0]            r2_u2_ff [4], r2_u2_in [4];
   logic signed [CENTER_W-1:0] r2_q_ff [4], r2_q_in [4];
   logic                       r2_left_ff [4], r2_left_in [4];
   logic                       r2_right_ff [4], r2_right_in [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         r2_u_in[r]     = (G_W'(1) << F) - r1_a_ff[r];
         r2_k_in[r]     = K_W'(r1_a_ff[r]) * (K_W'(G_W'(1) << F) + K_W'(r2_u_in[r]));
         r2_u2_in[r]    = U2_W'(r2_u_in[r]) * U2_W'(r2_u_in[r]);
         r2_q_in[r]     = CENTER_W'(out_start_ff)
                          + CENTER_W'(r1_code_ff[r]) * CENTER_W'(os);
         r2_left_in[r]  = (r1_code_ff[r] == CODE_LEFT);
         r2_right_in[r] = (r1_code_ff[r] == CODE_RIGHT);
      end
   end

   always_ff @(posedge clock) begin
      r2_valid_ff <= reset ? 1'b0 : r1_valid_ff;
      r2_k_ff     <= r2_k_in;
      r2_u_ff     <= r2_u_in;
      r2_u2_ff    <= r2_u2_in;
      r2_q_ff     <= r2_q_in;
      r2_left_ff  <= r2_left_in;
      r2_right_ff <= r2_right_in;
   end

   // rule stage 3: weighted centers, cube term, denominator terms
   logic                   r3_valid_ff;
   logic signed [WQ_W-1:0] r3_wq_ff [4], r3_wq_in [4];
   logic [U3_W-1:0]        r3_u3_ff [4], r3_u3_in [4];
   logic [DT_W-1:0]        r3_dt_ff [4], r3_dt_in [4];
   logic                   r3_left_ff [4], r3_right_ff [4];

   always_comb begin
      logic [W_W-1:0] w;
      for (int r = 0; r < 4; r++) begin
         w = (r2_left_ff[r] || r2_right_ff[r]) ? {1'b0, r2_k_ff[r]} : {r2_k_ff[r], 1'b0};
         r3_wq_in[r] = $signed({1'b0, w}) * r2_q_ff[r];
         r3_u3_in[r] = U3_W'(r2_u2_ff[r]) * U3_W'(r2_u_ff[r]);
         r3_dt_in[r] = (DT_W'(w) + (DT_W'(w) << 1)) << F;
      end
   end

   always_ff @(posedge clock) begin
      r3_valid_ff <= reset ? 1'b0 : r2_valid_ff;
      r3_wq_ff    <= r3_wq_in;
      r3_u3_ff    <= r3_u3_in;
      r3_dt_ff    <= r3_dt_in;
      r3_left_ff  <= r2_left_ff;
      r3_right_ff <= r2_right_ff;
   end

   // rule stage 4: shoulder offset
   logic                   r4_valid_ff;
   logic [OFF_W-1:0]       r4_off_ff [4], r4_off_in [4];
   logic signed [WQ_W-1:0] r4_wq_ff [4];
   logic [DT_W-1:0]        r4_dt_ff [4];
   logic                   r4_left_ff [4], r4_right_ff [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         r4_off_in[r] = OFF_W'(os) * OFF_W'((U3_W'(1) << (3 * F)) - r3_u3_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      r4_valid_ff <= reset ? 1'b0 : r3_valid_ff;
      r4_off_ff   <= r4_off_in;
      r4_wq_ff    <= r3_wq_ff;
      r4_dt_ff    <= r3_dt_ff;
      r4_left_ff  <= r3_left_ff;
      r4_right_ff <= r3_right_ff;
   end

   // rule stage 5: numerator terms
   logic                   r5_valid_ff;
   logic signed [NT_W-1:0] r5_nt_ff [4], r5_nt_in [4];
   logic [DT_W-1:0]        r5_dt_ff [4];

   always_comb begin
      logic signed [NT_W-1:0] t3, offs;
      for (int r = 0; r < 4; r++) begin
         t3   = (NT_W'(r4_wq_ff[r]) + (NT_W'(r4_wq_ff[r]) <<< 1)) <<< F;
         offs = NT_W'(r4_off_ff[r]);
         r5_nt_in[r] = r4_left_ff[r] ? t3 + offs : r4_right_ff[r] ? t3 - offs : t3;
      end
   end

   always_ff @(posedge clock) begin
      r5_valid_ff <= reset ? 1'b0 : r4_valid_ff;
      r5_nt_ff    <= r5_nt_in;
      r5_dt_ff    <= r4_dt_ff;
   end

   // sum tree
   logic                   r6_valid_ff, r7_valid_ff;
   logic signed [NS_W-1:0] r6_ns_ff [2], r7_ns_ff;
   logic [DS_W-1:0]        r6_ds_ff [2], r7_ds_ff;

   always_ff @(posedge clock) begin
      r6_valid_ff <= reset ? 1'b0 : r5_valid_ff;
      r7_valid_ff <= reset ? 1'b0 : r6_valid_ff;
      for (int p = 0; p < 2; p++) begin
         r6_ns_ff[p] <= NS_W'(r5_nt_ff[2*p]) + NS_W'(r5_nt_ff[2*p + 1]);
         r6_ds_ff[p] <= DS_W'(r5_dt_ff[2*p]) + DS_W'(r5_dt_ff[2*p + 1]);
      end
      r7_ns_ff <= r6_ns_ff[0] + r6_ns_ff[1];
      r7_ds_ff <= r6_ds_ff[0] + r6_ds_ff[1];
   end

   // rounding setup: floor((2*num + den) / (2*den))
   logic                   r8_valid_ff;
   quot_type               r8_ff, r8_in;

   always_comb begin
      logic signed [N2_W-1:0] n2;
      n2 = (N2_W'(r7_ns_ff) <<< 1) + N2_W'(r7_ds_ff);
      r8_in.neg  = n2[N2_W-1];
      r8_in.rem  = n2[N2_W-1] ? N2_W'(-n2) : N2_W'(n2);
      r8_in.quo  = '0;
      r8_in.den  = D2_W'(r7_ds_ff) << 1;
      r8_in.zero = (r7_ds_ff == '0);
   end

   always_ff @(posedge clock) begin
      r8_valid_ff <= reset ? 1'b0 : r7_valid_ff;
      r8_ff       <= r8_in;
   end

   // centroid divider: one quotient bit per stage, most significant first
   logic     qd_valid_ff [QUO_BITS];
   quot_type qd_ff [QUO_BITS];
   quot_type qd_in [QUO_BITS];

   always_comb begin
      quot_type       src;
      logic [C_W-1:0] sub;
      for (int j = 0; j < QUO_BITS; j++) begin
         src = (j == 0) ? r8_ff : qd_ff[(j == 0) ? 0 : j - 1];
         sub = C_W'(src.den) << (QUO_BITS - 1 - j);
         qd_in[j] = src;
         if (C_W'(src.rem) >= sub) begin
            qd_in[j].rem = N2_W'(C_W'(src.rem) - sub);
            qd_in[j].quo[QUO_BITS - 1 - j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      qd_ff <= qd_in;
      for (int j = 0; j < QUO_BITS; j++) begin
         if (j == 0) begin
            qd_valid_ff[j] <= reset ? 1'b0 : r8_valid_ff;
         end else begin
            qd_valid_ff[j] <= reset ? 1'b0 : qd_valid_ff[j-1];
         end
      end
   end

   // sign fix, saturate, drive the result
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_gain_change_ff, rsp_gain_change_in;
   logic                     rsp_no_rule_fired_ff;

   always_comb begin
      logic signed [R_W-1:0] res;
      res = qd_ff[QUO_BITS-1].neg
            ? -(R_W'(qd_ff[QUO_BITS-1].quo) + R_W'(qd_ff[QUO_BITS-1].rem != '0))
            : R_W'(qd_ff[QUO_BITS-1].quo);
      if (qd_ff[QUO_BITS-1].zero) begin
         rsp_gain_change_in = '0;
      end else if (res > R_W'(32767)) begin
         rsp_gain_change_in = 16'sh7FFF;
      end else if (res < -R_W'(32768)) begin
         rsp_gain_change_in = -16'sh8000;
      end else begin
         rsp_gain_change_in = DATA_W'(res);
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff         <= reset ? 1'b0 : qd_valid_ff[QUO_BITS-1];
      rsp_gain_change_ff   <= rsp_gain_change_in;
      rsp_no_rule_fired_ff <= qd_ff[QUO_BITS-1].zero;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gain_change   = rsp_gain_change_ff;
   assign rsp_no_rule_fired = rsp_no_rule_fired_ff;

   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transfer did not produce a result at the expected cycle");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result strobe without a matching transfer");

   a_idle_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_rule_fired) |-> (rsp_gain_change == '0))
      else $error("nonzero output with no rule fired");

endmodule
